FILE: rtl/huffman_code_bit_packer_core_macros.svh
// Assertion macros shared by the packer RTL
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define HCBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define HCBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hcbp_pkg.sv
// Types and constants of the Huffman code bit packer
package hcbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int PAT_W        = 32;
  localparam int LEN_W        = 6;
  localparam int SYM_W        = 8;
  localparam int BYTE_W       = 8;
  localparam int CNT_W        = 3;
  localparam int TAKE_W       = 4;
  localparam int TABLE_DEPTH  = 256;
  localparam int LEN_CAP_INT  = (MAX_CODE_LEN < PAT_W) ? MAX_CODE_LEN : PAT_W;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic             flush;
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] pat;
  } job_t;

endpackage

FILE: rtl/hcbp_if.sv
// Channel interfaces of the Huffman code bit packer
interface hcbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  symbol;
  logic [5:0]  code_length;
  logic [31:0] code_bits;

  modport source (output valid, output command, output symbol, output code_length,
                  output code_bits, input ready);
  modport sink (input valid, input command, input symbol, input code_length,
                input code_bits, output ready);
endinterface

interface hcbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

FILE: rtl/hcbp_front.sv
// Front end: command decode, code table and lookup stage
`include "huffman_code_bit_packer_core_macros.svh"

module hcbp_front (
  input  logic           clk,
  input  logic           rst_n,
  hcbp_in_if.sink        in_ch,
  output logic           job_valid,
  input  logic           job_ready,
  output hcbp_pkg::job_t job
);
  import hcbp_pkg::*;

  logic [LEN_W-1:0] len_mem [TABLE_DEPTH];
  logic [PAT_W-1:0] pat_mem [TABLE_DEPTH];
  logic [LEN_W-1:0] rd_len_r;
  logic [PAT_W-1:0] rd_pat_r;
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_flush_r;
  logic             accept;
  logic             is_load, is_enc, is_flush;
  logic [LEN_W-1:0] len_capped;

  always_comb begin
    is_load  = 1'b0;
    is_enc   = 1'b0;
    is_flush = 1'b0;
    unique case (in_ch.command)
      CMD_LOAD:   is_load  = 1'b1;
      CMD_ENCODE: is_enc   = 1'b1;
      CMD_FLUSH:  is_flush = 1'b1;
      default: ;
    endcase
  end

  assign in_ch.ready = !s1_valid_r || job_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign len_capped  = (in_ch.code_length > LEN_CAP) ? LEN_CAP : in_ch.code_length;

  always_ff @(posedge clk) begin
    if (accept && is_load) begin
      len_mem[in_ch.symbol] <= len_capped;
      pat_mem[in_ch.symbol] <= in_ch.code_bits;
    end
    if (accept && is_enc) begin
      rd_len_r <= len_mem[in_ch.symbol];
      rd_pat_r <= pat_mem[in_ch.symbol];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = is_enc || is_flush;
    end else if (job_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (accept) begin
      s1_flush_r <= is_flush;
    end
  end

  assign job_valid = s1_valid_r;
  assign job.flush = s1_flush_r;
  assign job.len   = rd_len_r;
  assign job.pat   = rd_pat_r;

  `HCBP_ASSERT_NEXT(FRONT_ENC_STAGED, accept && is_enc, s1_valid_r && !s1_flush_r,
                    "encode transfer not staged for the packer")

endmodule

FILE: rtl/hcbp_queue.sv
// Short job queue between front end and packer
`include "huffman_code_bit_packer_core_macros.svh"

module hcbp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  hcbp_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output hcbp_pkg::job_t pop_job
);
  import hcbp_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push_fire, pop_fire;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_job    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `HCBP_ASSERT_NOW(QUEUE_BOUND, 1'b1, count_r <= QCNT_W'(QUEUE_DEPTH),
                   "queue occupancy beyond depth")
  `HCBP_ASSERT_NEXT(QUEUE_GROW, push_fire && !pop_fire, count_r == $past(count_r) + 1'b1,
                    "queue occupancy did not follow a lone push")

endmodule

FILE: rtl/hcbp_back.sv
// Back end: bit accumulator and byte output register
`include "huffman_code_bit_packer_core_macros.svh"

module hcbp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  hcbp_pkg::job_t pop_job,
  hcbp_out_if.source     out_ch
);
  import hcbp_pkg::*;

  logic              job_valid_r, job_valid_nxt;
  logic              job_flush_r;
  logic [LEN_W-1:0]  rem_r;
  logic [PAT_W-1:0]  pat_r;
  logic [BYTE_W-1:0] acc_bits_r;
  logic [CNT_W-1:0]  acc_cnt_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic [TAKE_W-1:0]   space, take, sum_cnt;
  logic [BYTE_W-1:0]   mask, merged;
  logic [2*BYTE_W-1:0] shifted;
  logic [LEN_W-1:0]    rem_left;
  logic                fill, out_free, emit, advance, job_done, pop_fire;

  assign space    = TAKE_W'(BYTE_W) - {1'b0, acc_cnt_r};
  assign take     = (rem_r < {{(LEN_W-TAKE_W){1'b0}}, space}) ? rem_r[TAKE_W-1:0] : space;
  assign mask     = BYTE_W'((9'd1 << take) - 9'd1);
  assign shifted  = {{BYTE_W{1'b0}}, pat_r[BYTE_W-1:0] & mask} << acc_cnt_r;
  assign merged   = acc_bits_r | shifted[BYTE_W-1:0];
  assign sum_cnt  = {1'b0, acc_cnt_r} + take;
  assign fill     = sum_cnt == TAKE_W'(BYTE_W);
  assign rem_left = rem_r - {{(LEN_W-TAKE_W){1'b0}}, take};

  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = job_valid_r && (job_flush_r || fill) && out_free;
  assign advance  = job_valid_r && (!(job_flush_r || fill) || out_free);
  assign job_done = advance && (job_flush_r || rem_left == '0);

  assign pop_ready = !job_valid_r || job_done;
  assign pop_fire  = pop_valid && pop_ready;

  always_comb begin
    job_valid_nxt = job_valid_r;
    if (pop_fire) begin
      job_valid_nxt = 1'b1;
    end else if (job_done) begin
      job_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      job_flush_r <= pop_job.flush;
      rem_r       <= pop_job.len;
      pat_r       <= pop_job.pat;
    end else if (advance) begin
      rem_r <= rem_left;
      pat_r <= pat_r >> take;
    end
    if (emit) begin
      out_byte_r <= job_flush_r ? acc_bits_r : merged;
      out_last_r <= job_flush_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      acc_bits_r  <= '0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      if (advance) begin
        if (job_flush_r || fill) begin
          acc_bits_r <= '0;
          acc_cnt_r  <= '0;
        end else begin
          acc_bits_r <= merged;
          acc_cnt_r  <= sum_cnt[CNT_W-1:0];
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.last_byte = out_last_r;

  `HCBP_ASSERT_NOW(BACK_ACC_CLEAN, 1'b1, (acc_bits_r >> acc_cnt_r) == '0,
                   "accumulator holds bits above its count")
  `HCBP_ASSERT_NEXT(BACK_FLUSH_EMPTY, emit && job_flush_r,
                    acc_cnt_r == '0 && out_valid_r && out_last_r,
                    "flush left bits behind or lost its last byte")

endmodule

FILE: rtl/huffman_code_bit_packer_core.sv
// Top level of the Huffman code bit packer. Load commands write a 256-entry
// code table (length saturated to 32, pattern bit 0 sent first); table entries
// are undefined until loaded and there is no clearing pass after reset. Encode
// commands look the symbol up and pack its code LSB first into bytes; flush
// sends the current byte zero-padded with last_byte set, even when empty. The
// input takes one item per cycle while the queue has room. Loads and unknown
// commands end in the front end and never reach the queue. In the packer an
// encode moves its code into the accumulator in steps, each one filling the
// current byte or taking the remainder; a step that fills a byte, and every
// flush, waits while the single byte-wide output register is still full.
module huffman_code_bit_packer_core (
  input logic         clk,
  input logic         rst_n,
  hcbp_in_if.sink     in_ch,
  hcbp_out_if.source  out_ch
);
  import hcbp_pkg::*;

  logic stage_valid, stage_ready;
  job_t stage_job;
  logic pop_valid, pop_ready;
  job_t pop_job;

  hcbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job_valid (stage_valid),
    .job_ready (stage_ready),
    .job       (stage_job)
  );

  hcbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (stage_valid),
    .push_ready (stage_ready),
    .push_job   (stage_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  hcbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

endmodule
